// ===== hdl/ofa_pkg.sv =====
`timescale 1ns / 1ps

package ofa_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 30;
    localparam int TIME_W         = 48;
    localparam int MAT_W          = 32;
    localparam int WIDE_W         = 64;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;

    // register indexes
    localparam logic REG_NADIR = 1'b0;

    // vector slots in the engine register file
    localparam logic [2:0] V_P = 3'd0;
    localparam logic [2:0] V_W = 3'd1;
    localparam logic [2:0] V_T = 3'd2;
    localparam logic [2:0] V_X = 3'd3;
    localparam logic [2:0] V_Y = 3'd4;
    localparam logic [2:0] V_Z = 3'd5;

    // macro operations of the engine program
    localparam logic [1:0] OP_END   = 2'd0;
    localparam logic [1:0] OP_CROSS = 2'd1;
    localparam logic [1:0] OP_UNIT  = 2'd2;

    typedef logic [2:0][WIDE_W-1:0] vec3_t;
    typedef logic [8:0][MAT_W-1:0]  mat_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] src_a;
        logic [2:0] src_b;
        logic [2:0] dst;
    } prog_op_t;

    typedef struct packed {
        logic start;
        logic nadir;
        logic usable;
    } eng_req_t;

    typedef struct packed {
        logic done;
        logic fail;
    } eng_sts_t;

    function automatic prog_op_t prog_fetch(input logic [2:0] pc, input logic nadir);
        prog_op_t op;
        op = '{kind: OP_END, src_a: V_P, src_b: V_P, dst: V_T};
        if (!nadir)
        begin
            unique case (pc)
                3'd0: op = '{kind: OP_CROSS, src_a: V_W, src_b: V_P, dst: V_T};
                3'd1: op = '{kind: OP_UNIT,  src_a: V_T, src_b: V_T, dst: V_Y};
                3'd2: op = '{kind: OP_UNIT,  src_a: V_W, src_b: V_W, dst: V_X};
                3'd3: op = '{kind: OP_CROSS, src_a: V_X, src_b: V_Y, dst: V_T};
                3'd4: op = '{kind: OP_UNIT,  src_a: V_T, src_b: V_T, dst: V_Z};
                default: op = '{kind: OP_END, src_a: V_P, src_b: V_P, dst: V_T};
            endcase
        end
        else
        begin
            unique case (pc)
                3'd0: op = '{kind: OP_CROSS, src_a: V_W, src_b: V_P, dst: V_T};
                3'd1: op = '{kind: OP_UNIT,  src_a: V_T, src_b: V_T, dst: V_Y};
                3'd2: op = '{kind: OP_CROSS, src_a: V_P, src_b: V_Y, dst: V_T};
                3'd3: op = '{kind: OP_UNIT,  src_a: V_T, src_b: V_T, dst: V_X};
                3'd4: op = '{kind: OP_CROSS, src_a: V_X, src_b: V_Y, dst: V_T};
                3'd5: op = '{kind: OP_UNIT,  src_a: V_T, src_b: V_T, dst: V_Z};
                default: op = '{kind: OP_END, src_a: V_P, src_b: V_P, dst: V_T};
            endcase
        end
        return op;
    endfunction

endpackage

// ===== hdl/ofa_alu.sv =====
`timescale 1ns / 1ps

module ofa_alu (
    input  logic                              clk,
    input  logic signed [ofa_pkg::MAT_W-1:0]  mul_a,
    input  logic signed [ofa_pkg::MAT_W-1:0]  mul_b,
    output logic signed [ofa_pkg::WIDE_W-1:0] prod,
    input  logic [ofa_pkg::WIDE_W:0]          sub_a,
    input  logic [ofa_pkg::WIDE_W:0]          sub_b,
    output logic [ofa_pkg::WIDE_W:0]          diff,
    output logic                              ge
);
    import ofa_pkg::*;

    logic signed [WIDE_W-1:0] prod_reg;
    logic [WIDE_W+1:0]        wide_diff;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod      = prod_reg;
    assign wide_diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign diff      = wide_diff[WIDE_W:0];
    assign ge        = ~wide_diff[WIDE_W+1];

endmodule

// ===== hdl/ofa_engine.sv =====
`timescale 1ns / 1ps

module ofa_engine #(
    parameter int FRAC_BITS = ofa_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ofa_pkg::eng_req_t req,
    input  ofa_pkg::vec3_t    pos_in,
    input  ofa_pkg::vec3_t    vel_in,
    output ofa_pkg::eng_sts_t sts,
    output ofa_pkg::mat_t     mat
);
    import ofa_pkg::*;

    localparam int Q_W  = FRAC_BITS + 1;
    localparam int DK_W = $clog2(FRAC_BITS + 1);

    localparam logic [3:0] E_IDLE  = 4'd0;
    localparam logic [3:0] E_FETCH = 4'd1;
    localparam logic [3:0] E_BSMAX = 4'd2;
    localparam logic [3:0] E_BSLZ  = 4'd3;
    localparam logic [3:0] E_BSSH  = 4'd4;
    localparam logic [3:0] E_MUL   = 4'd5;
    localparam logic [3:0] E_SQRT  = 4'd6;
    localparam logic [3:0] E_DIV   = 4'd7;
    localparam logic [3:0] E_DONE  = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [2:0]  pc_reg, pc_next;
    logic        bs_sel_reg, bs_sel_next;
    logic [2:0]  lz_reg, lz_next;
    logic [2:0]  mi_reg, mi_next;
    logic [4:0]  sq_reg, sq_next;
    logic [1:0]  di_reg, di_next;
    logic [DK_W-1:0] dk_reg, dk_next;
    logic        nadir_reg, nadir_next;
    logic        fail_reg, fail_next;

    logic [WIDE_W-1:0]       vec_reg [6][3];
    logic signed [MAT_W-1:0] sa_reg [3];
    logic signed [MAT_W-1:0] sb_reg [3];
    logic [WIDE_W-1:0]       m_reg;
    logic [5:0]              top_reg;
    logic signed [WIDE_W-1:0] acc_reg;
    logic [WIDE_W-1:0]       n_reg;
    logic [WIDE_W-1:0]       res_reg;
    logic [33:0]             r_reg;
    logic [Q_W-1:0]          q_reg;

    prog_op_t                cur;
    logic [2:0]              src_idx;
    logic [WIDE_W-1:0]       mag [3];
    logic [WIDE_W-1:0]       m_max;
    logic [5:0]              lz_k;
    logic [WIDE_W-1:0]       lz_shift;
    logic [WIDE_W-1:0]       a_sh [3];
    logic signed [MAT_W-1:0] scaled [3];
    logic [2:0]              mul_cnt;
    logic signed [MAT_W-1:0] mul_a, mul_b;
    logic signed [WIDE_W-1:0] prod;
    logic [WIDE_W:0]         sub_a, sub_b, diff;
    logic                    ge;
    logic [WIDE_W-1:0]       bit_val;
    logic [MAT_W-1:0]        sa_neg;
    logic [30:0]             a_div;
    logic [33:0]             r_next;
    logic [Q_W-1:0]          q_next;
    logic [WIDE_W-1:0]       q_ext;
    logic [WIDE_W-1:0]       q_signed;
    logic [2:0]              j_idx;

    ofa_alu u_alu (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod),
        .sub_a (sub_a),
        .sub_b (sub_b),
        .diff  (diff),
        .ge    (ge)
    );

    assign cur     = prog_fetch(pc_reg, nadir_reg);
    assign src_idx = (cur.kind == OP_CROSS && bs_sel_reg) ? cur.src_b : cur.src_a;
    assign mul_cnt = (cur.kind == OP_CROSS) ? 3'd6 : 3'd3;
    assign j_idx   = mi_reg - 3'd1;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = vec_reg[src_idx][i][WIDE_W-1] ? (~vec_reg[src_idx][i] + 1'b1)
                                                   : vec_reg[src_idx][i];
            if (top_reg > 6'd30)
                a_sh[i] = mag[i] >> (top_reg - 6'd30);
            else
                a_sh[i] = mag[i] << (6'd30 - top_reg);
            scaled[i] = vec_reg[src_idx][i][WIDE_W-1] ? -$signed({1'b0, a_sh[i][30:0]})
                                                      : $signed({1'b0, a_sh[i][30:0]});
        end
        m_max = mag[0];
        if (mag[1] > m_max)
            m_max = mag[1];
        if (mag[2] > m_max)
            m_max = mag[2];
    end

    assign lz_k     = 6'd32 >> lz_reg;
    assign lz_shift = m_reg >> lz_k;

    // multiplier operand order: each cross component is a pair, plus then minus
    always_comb
    begin
        mul_a = sa_reg[0];
        mul_b = sa_reg[0];
        if (cur.kind == OP_CROSS)
        begin
            case (mi_reg)
                3'd0: begin mul_a = sa_reg[1]; mul_b = sb_reg[2]; end
                3'd1: begin mul_a = sa_reg[2]; mul_b = sb_reg[1]; end
                3'd2: begin mul_a = sa_reg[2]; mul_b = sb_reg[0]; end
                3'd3: begin mul_a = sa_reg[0]; mul_b = sb_reg[2]; end
                3'd4: begin mul_a = sa_reg[0]; mul_b = sb_reg[1]; end
                3'd5: begin mul_a = sa_reg[1]; mul_b = sb_reg[0]; end
                default: begin mul_a = sa_reg[0]; mul_b = sb_reg[0]; end
            endcase
        end
        else
        begin
            case (mi_reg)
                3'd1:    begin mul_a = sa_reg[1]; mul_b = sa_reg[1]; end
                3'd2:    begin mul_a = sa_reg[2]; mul_b = sa_reg[2]; end
                default: begin mul_a = sa_reg[0]; mul_b = sa_reg[0]; end
            endcase
        end
    end

    assign bit_val = {{(WIDE_W-1){1'b0}}, 1'b1} << (6'd62 - {sq_reg, 1'b0});
    assign sa_neg  = -sa_reg[di_reg];
    assign a_div   = sa_reg[di_reg][MAT_W-1] ? sa_neg[30:0] : sa_reg[di_reg][30:0];

    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        if (state_reg == E_SQRT)
        begin
            sub_a = {1'b0, n_reg};
            sub_b = {1'b0, res_reg} + {1'b0, bit_val};
        end
        else
        begin
            if (dk_reg == '0)
                sub_a = {{(WIDE_W-30){1'b0}}, a_div};
            else
                sub_a = {{(WIDE_W-34){1'b0}}, r_reg, 1'b0};
            sub_b = {{(WIDE_W-32){1'b0}}, res_reg[32:0]};
        end
    end

    always_comb
    begin
        r_next = ge ? diff[33:0] : sub_a[33:0];
        if (dk_reg == '0)
            q_next = {{(Q_W-1){1'b0}}, ge};
        else
            q_next = {q_reg[Q_W-2:0], ge};
        q_ext    = {{(WIDE_W-Q_W){1'b0}}, q_next};
        q_signed = sa_reg[di_reg][MAT_W-1] ? -q_ext : q_ext;
    end

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        bs_sel_next = bs_sel_reg;
        lz_next     = lz_reg;
        mi_next     = mi_reg;
        sq_next     = sq_reg;
        di_next     = di_reg;
        dk_next     = dk_reg;
        nadir_next  = nadir_reg;
        fail_next   = fail_reg;
        unique case (state_reg) inside
            E_IDLE, E_DONE:
            begin
                if (req.start)
                begin
                    nadir_next = req.nadir;
                    fail_next  = ~req.usable;
                    pc_next    = '0;
                    state_next = req.usable ? E_FETCH : E_DONE;
                end
            end
            E_FETCH:
            begin
                bs_sel_next = 1'b0;
                state_next  = (cur.kind == OP_END) ? E_DONE : E_BSMAX;
            end
            E_BSMAX:
            begin
                lz_next = '0;
                if (m_max == '0)
                begin
                    fail_next  = 1'b1;
                    state_next = E_DONE;
                end
                else
                    state_next = E_BSLZ;
            end
            E_BSLZ:
            begin
                lz_next = lz_reg + 3'd1;
                if (lz_reg == 3'd5)
                    state_next = E_BSSH;
            end
            E_BSSH:
            begin
                mi_next = '0;
                if (cur.kind == OP_CROSS && !bs_sel_reg)
                begin
                    bs_sel_next = 1'b1;
                    state_next  = E_BSMAX;
                end
                else
                    state_next = E_MUL;
            end
            E_MUL:
            begin
                mi_next = mi_reg + 3'd1;
                sq_next = '0;
                if (mi_reg == mul_cnt)
                begin
                    if (cur.kind == OP_CROSS)
                    begin
                        pc_next    = pc_reg + 3'd1;
                        state_next = E_FETCH;
                    end
                    else
                        state_next = E_SQRT;
                end
            end
            E_SQRT:
            begin
                sq_next = sq_reg + 5'd1;
                di_next = '0;
                dk_next = '0;
                if (sq_reg == 5'd31)
                    state_next = E_DIV;
            end
            E_DIV:
            begin
                if (dk_reg == DK_W'(FRAC_BITS))
                begin
                    dk_next = '0;
                    di_next = di_reg + 2'd1;
                    if (di_reg == 2'd2)
                    begin
                        pc_next    = pc_reg + 3'd1;
                        state_next = E_FETCH;
                    end
                end
                else
                    dk_next = dk_reg + DK_W'(1);
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= E_IDLE;
            pc_reg     <= '0;
            bs_sel_reg <= 1'b0;
            lz_reg     <= '0;
            mi_reg     <= '0;
            sq_reg     <= '0;
            di_reg     <= '0;
            dk_reg     <= '0;
            nadir_reg  <= 1'b0;
            fail_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            bs_sel_reg <= bs_sel_next;
            lz_reg     <= lz_next;
            mi_reg     <= mi_next;
            sq_reg     <= sq_next;
            di_reg     <= di_next;
            dk_reg     <= dk_next;
            nadir_reg  <= nadir_next;
            fail_reg   <= fail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg) inside
            E_IDLE, E_DONE:
            begin
                if (req.start)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        vec_reg[V_P][i] <= pos_in[i];
                        vec_reg[V_W][i] <= vel_in[i];
                    end
                end
            end
            E_BSMAX:
            begin
                m_reg   <= m_max;
                top_reg <= '0;
            end
            E_BSLZ:
            begin
                // advance the leading-one search by halving steps
                if (lz_shift != '0)
                begin
                    m_reg   <= lz_shift;
                    top_reg <= top_reg + lz_k;
                end
            end
            E_BSSH:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (bs_sel_reg)
                        sb_reg[i] <= scaled[i];
                    else
                        sa_reg[i] <= scaled[i];
                end
                acc_reg <= '0;
                n_reg   <= '0;
            end
            E_MUL:
            begin
                if (mi_reg != 3'd0)
                begin
                    if (cur.kind == OP_CROSS)
                    begin
                        if (j_idx[0])
                            vec_reg[cur.dst][j_idx[2:1]] <= acc_reg - prod;
                        else
                            acc_reg <= prod;
                    end
                    else
                        n_reg <= n_reg + prod;
                end
                res_reg <= '0;
            end
            E_SQRT:
            begin
                if (ge)
                begin
                    n_reg   <= diff[WIDE_W-1:0];
                    res_reg <= (res_reg >> 1) + bit_val;
                end
                else
                    res_reg <= res_reg >> 1;
            end
            E_DIV:
            begin
                r_reg <= r_next;
                q_reg <= q_next;
                if (dk_reg == DK_W'(FRAC_BITS))
                    vec_reg[cur.dst][di_reg] <= q_signed;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mat[i]     = fail_reg ? '0 : vec_reg[V_X][i][MAT_W-1:0];
            mat[3 + i] = fail_reg ? '0 : vec_reg[V_Y][i][MAT_W-1:0];
            mat[6 + i] = fail_reg ? '0 : vec_reg[V_Z][i][MAT_W-1:0];
        end
    end

    assign sts.done = (state_reg == E_DONE);
    assign sts.fail = fail_reg;

endmodule

// ===== hdl/orbit_frame_attitude_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  epoch_time, pos_*, vel_*, arc_end
// output    out        out_valid / out_stall out_time, r00..r22, degenerate, last_of_run
// config    in         APB write/read       nadir_pointing at byte address 0
//
// Each rotation runs on one shared multiplier and one subtractor under a sequencer:
// along mode runs two cross products and three unit vectors, nadir mode one cross
// product more, one step after another, and an
// epoch yields zero, one or two rotations. in_stall is high until the last rotation of
// the epoch has moved into the output register; out_stall holds that register.
// Reset clears the held and prior epoch marks, the sequencers and nadir_pointing.

module orbit_frame_attitude_top #(
    parameter int COORD_BITS = ofa_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = ofa_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ofa_pkg::TIME_W-1:0]        epoch_time,
    input  logic signed [COORD_BITS-1:0]      pos_x,
    input  logic signed [COORD_BITS-1:0]      pos_y,
    input  logic signed [COORD_BITS-1:0]      pos_z,
    input  logic signed [COORD_BITS-1:0]      vel_x,
    input  logic signed [COORD_BITS-1:0]      vel_y,
    input  logic signed [COORD_BITS-1:0]      vel_z,
    input  logic                              arc_end,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ofa_pkg::TIME_W-1:0]        out_time,
    output logic signed [ofa_pkg::MAT_W-1:0]  r00,
    output logic signed [ofa_pkg::MAT_W-1:0]  r10,
    output logic signed [ofa_pkg::MAT_W-1:0]  r20,
    output logic signed [ofa_pkg::MAT_W-1:0]  r01,
    output logic signed [ofa_pkg::MAT_W-1:0]  r11,
    output logic signed [ofa_pkg::MAT_W-1:0]  r21,
    output logic signed [ofa_pkg::MAT_W-1:0]  r02,
    output logic signed [ofa_pkg::MAT_W-1:0]  r12,
    output logic signed [ofa_pkg::MAT_W-1:0]  r22,
    output logic                              degenerate,
    output logic                              last_of_run,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ofa_pkg::APB_AW-1:0]        paddr,
    input  logic [ofa_pkg::APB_DW-1:0]        pwdata,
    output logic [ofa_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);
    import ofa_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_GO_A   = 3'd1;
    localparam logic [2:0] ST_WAIT_A = 3'd2;
    localparam logic [2:0] ST_GO_B   = 3'd3;
    localparam logic [2:0] ST_WAIT_B = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic        nadir_reg;
    logic        held_valid_reg, prior_valid_reg;
    logic        need_b_reg;
    logic        out_valid_reg, out_valid_next;

    logic [TIME_W-1:0] held_time_reg;
    vec3_t             held_pos_reg, held_vel_reg, prior_pos_reg;
    logic [TIME_W-1:0] ja_time_reg, jb_time_reg;
    vec3_t             ja_pos_reg, ja_w_reg, jb_pos_reg, jb_w_reg;
    logic              ja_last_reg, jb_usable_reg;
    logic [TIME_W-1:0] out_time_reg;
    mat_t              out_mat_reg;
    logic              out_degen_reg, out_last_reg;

    logic              in_acc, cfg_wr, out_free, load_out, use_b;
    vec3_t             p_in, v_in, wa, wb, prior_eff;
    logic              held_zero, vel_zero, prior_eff_valid;
    eng_req_t          req;
    eng_sts_t          sts;
    mat_t              mat;

    assign in_acc   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_NADIR) ? {{(APB_DW-1){1'b0}}, nadir_reg} : '0;

    assign p_in[0] = {{(WIDE_W-COORD_BITS){pos_x[COORD_BITS-1]}}, pos_x};
    assign p_in[1] = {{(WIDE_W-COORD_BITS){pos_y[COORD_BITS-1]}}, pos_y};
    assign p_in[2] = {{(WIDE_W-COORD_BITS){pos_z[COORD_BITS-1]}}, pos_z};
    assign v_in[0] = {{(WIDE_W-COORD_BITS){vel_x[COORD_BITS-1]}}, vel_x};
    assign v_in[1] = {{(WIDE_W-COORD_BITS){vel_y[COORD_BITS-1]}}, vel_y};
    assign v_in[2] = {{(WIDE_W-COORD_BITS){vel_z[COORD_BITS-1]}}, vel_z};

    assign held_zero       = (held_vel_reg == '0);
    assign vel_zero        = (v_in == '0);
    assign prior_eff_valid = held_valid_reg || prior_valid_reg;
    assign prior_eff       = held_valid_reg ? held_pos_reg : prior_pos_reg;

    // zero velocity falls back on a position difference
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wa[i] = held_zero ? (p_in[i] - held_pos_reg[i]) : held_vel_reg[i];
            wb[i] = vel_zero ? (p_in[i] - prior_eff[i]) : v_in[i];
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign load_out = sts.done && out_free &&
                      (state_reg == ST_WAIT_A || state_reg == ST_WAIT_B);
    assign use_b    = (state_reg == ST_GO_B || state_reg == ST_WAIT_B);

    assign req.start  = (state_reg == ST_GO_A || state_reg == ST_GO_B);
    assign req.nadir  = nadir_reg;
    assign req.usable = use_b ? jb_usable_reg : 1'b1;

    ofa_engine #(
        .FRAC_BITS (FRAC_BITS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .pos_in (use_b ? jb_pos_reg : ja_pos_reg),
        .vel_in (use_b ? jb_w_reg : ja_w_reg),
        .sts    (sts),
        .mat    (mat)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (held_valid_reg)
                        state_next = ST_GO_A;
                    else if (arc_end)
                        state_next = ST_GO_B;
                end
            end
            ST_GO_A: state_next = ST_WAIT_A;
            ST_WAIT_A:
            begin
                if (load_out)
                    state_next = need_b_reg ? ST_GO_B : ST_IDLE;
            end
            ST_GO_B: state_next = ST_WAIT_B;
            ST_WAIT_B:
            begin
                if (load_out)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            nadir_reg       <= 1'b0;
            held_valid_reg  <= 1'b0;
            prior_valid_reg <= 1'b0;
            need_b_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr && paddr[2] == REG_NADIR)
                nadir_reg <= pwdata[0];
            if (in_acc)
            begin
                need_b_reg <= arc_end;
                if (arc_end)
                begin
                    held_valid_reg  <= 1'b0;
                    prior_valid_reg <= 1'b0;
                end
                else
                begin
                    held_valid_reg <= 1'b1;
                    if (held_valid_reg)
                        prior_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ja_time_reg   <= held_time_reg;
            ja_pos_reg    <= held_pos_reg;
            ja_w_reg      <= wa;
            ja_last_reg   <= ~arc_end;
            jb_time_reg   <= epoch_time;
            jb_pos_reg    <= p_in;
            jb_w_reg      <= wb;
            jb_usable_reg <= ~vel_zero || prior_eff_valid;
            if (held_valid_reg)
                prior_pos_reg <= held_pos_reg;
            if (!arc_end)
            begin
                held_time_reg <= epoch_time;
                held_pos_reg  <= p_in;
                held_vel_reg  <= v_in;
            end
        end
        if (load_out)
        begin
            out_time_reg  <= use_b ? jb_time_reg : ja_time_reg;
            out_mat_reg   <= mat;
            out_degen_reg <= sts.fail;
            out_last_reg  <= use_b ? 1'b1 : ja_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_time    = out_time_reg;
    assign r00         = out_mat_reg[0];
    assign r10         = out_mat_reg[1];
    assign r20         = out_mat_reg[2];
    assign r01         = out_mat_reg[3];
    assign r11         = out_mat_reg[4];
    assign r21         = out_mat_reg[5];
    assign r02         = out_mat_reg[6];
    assign r12         = out_mat_reg[7];
    assign r22         = out_mat_reg[8];
    assign degenerate  = out_degen_reg;
    assign last_of_run = out_last_reg;

endmodule

// ===== bench/ofa_checker.sv =====
`timescale 1ns / 1ps

module ofa_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [ofa_pkg::TIME_W-1:0]        epoch_time,
    input  logic signed [31:0]                pos_x,
    input  logic signed [31:0]                pos_y,
    input  logic signed [31:0]                pos_z,
    input  logic signed [31:0]                vel_x,
    input  logic signed [31:0]                vel_y,
    input  logic signed [31:0]                vel_z,
    input  logic                              arc_end,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [ofa_pkg::TIME_W-1:0]        out_time,
    input  logic signed [ofa_pkg::MAT_W-1:0]  r00,
    input  logic signed [ofa_pkg::MAT_W-1:0]  r10,
    input  logic signed [ofa_pkg::MAT_W-1:0]  r20,
    input  logic signed [ofa_pkg::MAT_W-1:0]  r01,
    input  logic signed [ofa_pkg::MAT_W-1:0]  r11,
    input  logic signed [ofa_pkg::MAT_W-1:0]  r21,
    input  logic signed [ofa_pkg::MAT_W-1:0]  r02,
    input  logic signed [ofa_pkg::MAT_W-1:0]  r12,
    input  logic signed [ofa_pkg::MAT_W-1:0]  r22,
    input  logic                              degenerate,
    input  logic                              last_of_run,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ofa_pkg::APB_AW-1:0]        paddr,
    input  logic [ofa_pkg::APB_DW-1:0]        pwdata,
    input  logic                              pready,
    output int                                fail_count,
    output int                                pending
);
    import ofa_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;

    typedef struct {
        logic [TIME_W-1:0] t;
        logic [MAT_W-1:0]  m[9];
        logic              degen;
        logic              last;
    } rotation_t;

    rotation_t rotations_due[$];

    logic          nadir_mode;
    logic          held_valid;
    logic [47:0]   held_time;
    longint signed held_pos[3];
    longint signed held_vel[3];
    longint signed prior_pos[3];
    logic          prior_valid;

    assign pending = rotations_due.size();

    function automatic longint unsigned mag(input longint signed v);
        return v < 0 ? longint'(-(v + 1)) + 64'd1 : v;
    endfunction

    function automatic bit norm_scale(input longint signed a[3], output longint signed o[3]);
        longint unsigned m;
        longint unsigned g;
        int top;
        m = 0;
        top = 0;
        for (int i = 0; i < 3; i++)
        begin
            g = mag(a[i]);
            if (g > m)
                m = g;
        end
        if (m == 0)
            return 0;
        while ((m >> top) > 1)
            top++;
        for (int i = 0; i < 3; i++)
        begin
            g = mag(a[i]);
            if (top > 30)
                g = g >> (top - 30);
            else
                g = g << (30 - top);
            o[i] = a[i] < 0 ? -longint'(g) : longint'(g);
        end
        return 1;
    endfunction

    function automatic bit cross3(input longint signed a[3], input longint signed b[3],
                                  output longint signed o[3]);
        longint signed sa[3];
        longint signed sb[3];
        if (!norm_scale(a, sa) || !norm_scale(b, sb))
            return 0;
        o[0] = sa[1] * sb[2] - sa[2] * sb[1];
        o[1] = sa[2] * sb[0] - sa[0] * sb[2];
        o[2] = sa[0] * sb[1] - sa[1] * sb[0];
        return 1;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit unit3(input longint signed a[3], output longint signed o[3]);
        longint signed s3[3];
        longint unsigned n;
        longint unsigned s;
        longint unsigned g;
        longint unsigned q;
        longint unsigned r;
        n = 0;
        if (!norm_scale(a, s3))
            return 0;
        for (int i = 0; i < 3; i++)
        begin
            g = mag(s3[i]);
            n = n + g * g;
        end
        s = int_sqrt(n);
        if (s == 0)
            return 0;
        for (int i = 0; i < 3; i++)
        begin
            g = mag(s3[i]);
            q = g / s;
            r = g % s;
            for (int k = 0; k < FRAC; k++)
            begin
                r = r << 1;
                q = q << 1;
                if (r >= s)
                begin
                    r = r - s;
                    q = q | 64'd1;
                end
            end
            o[i] = s3[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic rotation_t frame_rotation(input logic [47:0] t, input longint signed p[3],
                                                 input longint signed w[3], input bit usable);
        rotation_t rot;
        longint signed ax[3];
        longint signed ay[3];
        longint signed az[3];
        longint signed tmp[3];
        bit ok;
        ok = usable;
        if (ok)
            ok = cross3(w, p, tmp) && unit3(tmp, ay);
        if (ok)
        begin
            if (nadir_mode)
                ok = cross3(p, ay, tmp) && unit3(tmp, ax);
            else
                ok = unit3(w, ax);
        end
        if (ok)
            ok = cross3(ax, ay, tmp) && unit3(tmp, az);
        rot.t = t;
        for (int i = 0; i < 3; i++)
        begin
            rot.m[i]     = ok ? ax[i][31:0] : '0;
            rot.m[3 + i] = ok ? ay[i][31:0] : '0;
            rot.m[6 + i] = ok ? az[i][31:0] : '0;
        end
        rot.degen = !ok;
        rot.last = 1'b0;
        return rot;
    endfunction

    function automatic bit is_null(input longint signed a[3]);
        return a[0] == 0 && a[1] == 0 && a[2] == 0;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t: mismatch in %s: expected %h, got %h", $time, field, want, got);
        fail_count++;
    endtask

    task automatic queue_rotation(input rotation_t rot);
        rotations_due.insert(rotations_due.size(), rot);
    endtask

    task automatic predict_epoch();
        longint signed p[3];
        longint signed v[3];
        longint signed w[3];
        rotation_t rot;
        rotation_t last_rot;
        bit any;
        bit usable;
        any = 0;
        p = '{longint'(pos_x), longint'(pos_y), longint'(pos_z)};
        v = '{longint'(vel_x), longint'(vel_y), longint'(vel_z)};
        if (held_valid)
        begin
            for (int i = 0; i < 3; i++)
                w[i] = is_null(held_vel) ? p[i] - held_pos[i] : held_vel[i];
            rot = frame_rotation(held_time, held_pos, w, 1);
            any = 1;
            prior_pos = held_pos;
            prior_valid = 1;
            if (arc_end)
                queue_rotation(rot);
            else
                last_rot = rot;
        end
        if (arc_end)
        begin
            usable = 1;
            w = v;
            if (is_null(v))
            begin
                if (prior_valid)
                    for (int i = 0; i < 3; i++)
                        w[i] = p[i] - prior_pos[i];
                else
                    usable = 0;
            end
            last_rot = frame_rotation(epoch_time, p, w, usable);
            any = 1;
            held_valid = 0;
            prior_valid = 0;
        end
        else
        begin
            held_time = epoch_time;
            held_pos = p;
            held_vel = v;
            held_valid = 1;
        end
        if (any)
        begin
            last_rot.last = 1'b1;
            queue_rotation(last_rot);
        end
    endtask

    task automatic check_rotation();
        rotation_t want;
        logic [MAT_W-1:0] got_m[9];
        got_m = '{r00, r10, r20, r01, r11, r21, r02, r12, r22};
        if (rotations_due.size() == 0)
        begin
            report_mismatch("unexpected rotation", '0, {16'd0, out_time});
            return;
        end
        want = rotations_due.pop_front();
        if (out_time !== want.t)
            report_mismatch("out_time", {16'd0, want.t}, {16'd0, out_time});
        for (int i = 0; i < 9; i++)
            if (got_m[i] !== want.m[i])
                report_mismatch($sformatf("r%0d%0d", i % 3, i / 3), {32'd0, want.m[i]},
                                {32'd0, got_m[i]});
        if (degenerate !== want.degen)
            report_mismatch("degenerate", {63'd0, want.degen}, {63'd0, degenerate});
        if (last_of_run !== want.last)
            report_mismatch("last_of_run", {63'd0, want.last}, {63'd0, last_of_run});
    endtask

    initial
    begin
        fail_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nadir_mode = 1'b0;
            held_valid = 1'b0;
            prior_valid = 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == {APB_AW{1'b0}})
                nadir_mode = pwdata[0];
            // results out come from earlier requests, so compare before predicting
            if (out_valid && !out_stall)
                check_rotation();
            if (in_valid && !in_stall)
                predict_epoch();
        end
    end

endmodule

// ===== bench/tb_orbit_frame_attitude_top.sv =====
`timescale 1ns / 1ps

module tb_orbit_frame_attitude_top;
    import ofa_pkg::*;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [TIME_W-1:0]       epoch_time = '0;
    logic signed [31:0]      pos_x = '0;
    logic signed [31:0]      pos_y = '0;
    logic signed [31:0]      pos_z = '0;
    logic signed [31:0]      vel_x = '0;
    logic signed [31:0]      vel_y = '0;
    logic signed [31:0]      vel_z = '0;
    logic                    arc_end = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [TIME_W-1:0]       out_time;
    logic signed [MAT_W-1:0] r00, r10, r20, r01, r11, r21, r02, r12, r22;
    logic                    degenerate;
    logic                    last_of_run;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_AW-1:0]       paddr = '0;
    logic [APB_DW-1:0]       pwdata = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;
    int                      fail_count;
    int                      pending;

    int idle_pct = 0;
    int stall_pct = 0;
    localparam int SETTLE = 1500;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    orbit_frame_attitude_top DUT (.*);
    ofa_checker u_checker (.*);

    always @(negedge clk)
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);

    initial
    begin
        #20ms;
        $display("[orbit_frame_attitude_top] ERROR");
        $finish;
    end

    task automatic write_nadir(input logic value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {REG_NADIR, 2'b00};
        pwdata = {31'd0, value};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic send_epoch(input logic [47:0] t, input logic [31:0] px, py, pz,
                              input logic [31:0] vx, vy, vz, input logic last);
        bit taken;
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        epoch_time = t;
        pos_x = px;
        pos_y = py;
        pos_z = pz;
        vel_x = vx;
        vel_y = vy;
        vel_z = vz;
        arc_end = last;
        in_valid = 1'b1;
        // stall is stable between edges, so read it at the falling edge for the coming edge
        taken = 1'b0;
        while (!taken)
        begin
            taken = !in_stall;
            @(posedge clk);
            @(negedge clk);
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
            1: return 32'($signed($urandom) >>> $urandom_range(31));
            2: return 32'($urandom_range(3)) - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic directed_epochs();
        // single-epoch arcs: normal, zero velocity, zero position, parallel, full-scale corners
        send_epoch(48'hffff_ffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'd12345,
                   32'd100, 32'h8000_0000, 32'h7fff_ffff, 1'b1);
        send_epoch(48'd0, 32'd7000000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
        send_epoch(48'd1, 32'd0, 32'd0, 32'd0, 32'd5, 32'd6, 32'd7, 1'b1);
        send_epoch(48'd2, 32'd100, 32'd200, 32'd300, 32'd1, 32'd2, 32'd3, 1'b1);
        send_epoch(48'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 1'b1);
        // arc with zero velocity in the middle and at the end
        send_epoch(48'd10, 32'd7000000, 32'd0, 32'd0, 32'd0, 32'd7500, 32'd0, 1'b0);
        send_epoch(48'd11, 32'd6999000, 32'd75000, 32'd10, 32'd0, 32'd0, 32'd0, 1'b0);
        send_epoch(48'd12, 32'd6996000, 32'd150000, 32'd20, 32'hffff_fff0, 32'd7499,
                   32'd1, 1'b0);
        send_epoch(48'd13, 32'd6991000, 32'd225000, 32'd30, 32'd0, 32'd0, 32'd0, 1'b1);
        // zero velocity with a repeated position gives a zero substitute
        send_epoch(48'd20, 32'd5, 32'd5, 32'd5, 32'd0, 32'd0, 32'd0, 1'b0);
        send_epoch(48'd21, 32'd5, 32'd5, 32'd5, 32'd0, 32'd0, 32'd0, 1'b1);
        send_epoch(48'd30, 32'hffff_ffff, 32'd1, 32'd0, 32'd1, 32'd1, 32'd0, 1'b0);
        send_epoch(48'd31, 32'd2, 32'hffff_fffe, 32'd1, 32'd0, 32'd0, 32'd0, 1'b1);
    endtask

    task automatic random_arcs(input int count);
        int sent;
        int len;
        logic [31:0] p[3];
        logic [31:0] v[3];
        sent = 0;
        while (sent < count)
        begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                for (int i = 0; i < 3; i++)
                    p[i] = rand_coord();
                if ($urandom_range(99) < 15)
                    v = '{32'd0, 32'd0, 32'd0};
                else if ($urandom_range(99) < 5)
                    v = p;
                else
                    for (int i = 0; i < 3; i++)
                        v[i] = rand_coord();
                if ($urandom_range(99) < 3)
                    p = '{32'd0, 32'd0, 32'd0};
                send_epoch(48'({$urandom, $urandom}), p[0], p[1], p[2], v[0], v[1], v[2],
                           k == len - 1);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int mode = 0; mode < 2; mode++)
        begin
            write_nadir(mode[0]);
            idle_pct = 0;
            stall_pct = 0;
            directed_epochs();
            drain();
            for (int ph = 0; ph < 4; ph++)
            begin
                idle_pct = (ph == 1 || ph == 3) ? 79 : 0;
                stall_pct = ph == 2 ? 79 : 0;
                if (ph == 3)
                begin
                    idle_pct = 24;
                    stall_pct = 24;
                end
                random_arcs(60);
                drain();
            end
        end
        stall_pct = 0;
        write_nadir(1'b0);
        if (fail_count == 0)
            $display("[orbit_frame_attitude_top] OK");
        else
            $display("[orbit_frame_attitude_top] ERROR");
        $finish;
    end

endmodule
